// File: sv/mpf_pkg.sv
// Shared types and constants of the MQTT PUBLISH packet framer.
package mpf_pkg;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_TOPIC   = 2'd1,
    CMD_PAYLOAD = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    JOB_ERR   = 2'd0,
    JOB_START = 2'd1,
    JOB_DATA  = 2'd2
  } job_kind_t;

  localparam logic [7:0]  HDR_PUBLISH = 8'h30;
  localparam logic [28:0] VARINT_MAX  = 29'd268435455;
  localparam logic [28:0] MAX_RESET   = 29'd1024;

  // one queued job: a start header sequence, a data byte (with optional id) or an error
  typedef struct packed {
    job_kind_t   kind;
    logic [7:0]  first;     // header byte for start, data byte for data
    logic [27:0] rem;       // remaining length
    logic [1:0]  nlen_m1;   // varint bytes minus one
    logic [15:0] tlen;
    logic [15:0] pid;
    logic        with_id;   // packet id bytes close the job
    logic        last;      // final job byte ends the frame
    logic [28:0] total;
  } job_t;

endpackage

// File: sv/mpf_front.sv
// Front part: takes items, tracks frame state and queues jobs for the back part.
module mpf_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_valid,
  input  logic [28:0]    cfg_data,
  input  logic           in_valid,
  input  logic           q_full,
  input  logic [1:0]     command,
  input  logic [15:0]    topic_len,
  input  logic [27:0]    payload_len,
  input  logic [1:0]     qos,
  input  logic           retain,
  input  logic [15:0]    packet_id,
  input  logic [7:0]     data_byte,
  output logic           in_stall,
  output logic           push,
  output mpf_pkg::job_t  job
);
  import mpf_pkg::*;

  logic [28:0] max_size;
  logic [15:0] topic_left;
  logic [27:0] payload_left;
  logic        need_id;
  logic [15:0] held_id;
  logic        dropping;

  logic [15:0] topic_left_next;
  logic [27:0] payload_left_next;
  logic        need_id_next;
  logic        dropping_next;

  logic        accept;
  logic [28:0] rem;
  logic [1:0]  nlen_m1;
  logic [28:0] total;
  logic        too_large;
  logic [15:0] tl_dec;
  logic [27:0] pl_dec;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign rem = 29'd2 + {13'd0, topic_len} + {1'b0, payload_len}
             + ((qos != 2'd0) ? 29'd2 : 29'd0);

  always_comb begin
    if (rem <= 29'd127) begin
      nlen_m1 = 2'd0;
    end else if (rem <= 29'd16383) begin
      nlen_m1 = 2'd1;
    end else if (rem <= 29'd2097151) begin
      nlen_m1 = 2'd2;
    end else begin
      nlen_m1 = 2'd3;
    end
  end

  assign total     = rem + 29'd2 + {27'd0, nlen_m1};
  assign too_large = (rem > VARINT_MAX) || (total > max_size);
  assign tl_dec    = topic_left - 16'd1;
  assign pl_dec    = payload_left - 28'd1;

  always_comb begin
    push              = 1'b0;
    job               = '0;
    job.kind          = JOB_DATA;
    job.first         = data_byte;
    job.pid           = held_id;
    topic_left_next   = topic_left;
    payload_left_next = payload_left;
    need_id_next      = need_id;
    dropping_next     = dropping;
    case (cmd_t'(command))
      CMD_START: begin
        push          = 1'b1;
        job.total     = total;
        job.pid       = packet_id;
        need_id_next  = 1'b0;
        if (too_large) begin
          job.kind          = JOB_ERR;
          job.first         = 8'd0;
          job.last          = 1'b1;
          dropping_next     = 1'b1;
          topic_left_next   = '0;
          payload_left_next = '0;
        end else begin
          job.kind          = JOB_START;
          job.first         = HDR_PUBLISH | {5'd0, qos, retain};
          job.rem           = rem[27:0];
          job.nlen_m1       = nlen_m1;
          job.tlen          = topic_len;
          job.with_id       = (topic_len == 16'd0) && (qos != 2'd0);
          job.last          = (topic_len == 16'd0) && (payload_len == 28'd0);
          dropping_next     = 1'b0;
          topic_left_next   = topic_len;
          payload_left_next = payload_len;
          need_id_next      = (qos != 2'd0) && (topic_len != 16'd0);
        end
      end
      CMD_TOPIC: begin
        if (!dropping && topic_left != 16'd0) begin
          push            = 1'b1;
          topic_left_next = tl_dec;
          if (tl_dec == 16'd0 && need_id) begin
            job.with_id  = 1'b1;
            job.last     = (payload_left == 28'd0);
            need_id_next = 1'b0;
          end else begin
            job.last = (tl_dec == 16'd0) && (payload_left == 28'd0);
          end
        end
      end
      CMD_PAYLOAD: begin
        if (!dropping && topic_left == 16'd0 && payload_left != 28'd0) begin
          push              = 1'b1;
          payload_left_next = pl_dec;
          job.last          = (pl_dec == 28'd0);
        end
      end
      default: begin
      end
    endcase
    if (!accept) begin
      push = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_size     <= MAX_RESET;
      topic_left   <= '0;
      payload_left <= '0;
      need_id      <= 1'b0;
      held_id      <= '0;
      dropping     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        max_size <= cfg_data;
      end
      if (accept) begin
        topic_left   <= topic_left_next;
        payload_left <= payload_left_next;
        need_id      <= need_id_next;
        dropping     <= dropping_next;
        if (cmd_t'(command) == CMD_START) begin
          held_id <= packet_id;
        end
      end
    end
  end

endmodule

// File: sv/mpf_queue.sv
// Short job queue between the front and back parts.
module mpf_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mpf_pkg::job_t  push_job,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output mpf_pkg::job_t  head_job
);
  import mpf_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// File: sv/mpf_back.sv
// Back part: expands queued jobs into frame bytes through an output register.
module mpf_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  mpf_pkg::job_t  head_job,
  input  logic           out_stall,
  output logic           pop,
  output logic           out_valid,
  output logic [7:0]     out_byte,
  output logic           last,
  output logic           status,
  output logic [28:0]    total_len
);
  import mpf_pkg::*;

  logic [3:0] step;
  logic [3:0] final_step;
  logic       advance;
  logic [7:0] sel_byte;
  logic [1:0] vk;
  logic [1:0] tj;
  logic [3:0] tj_full;
  logic [6:0] digit;
  logic       is_final;

  assign advance  = head_valid && (!out_valid || !out_stall);
  assign is_final = (step == final_step);
  assign pop      = advance && is_final;
  assign vk       = 2'(step - 4'd1);
  assign tj_full  = step - {2'd0, head_job.nlen_m1} - 4'd2;
  assign tj       = tj_full[1:0];

  always_comb begin
    case (vk)
      2'd0:    digit = head_job.rem[6:0];
      2'd1:    digit = head_job.rem[13:7];
      2'd2:    digit = head_job.rem[20:14];
      default: digit = head_job.rem[27:21];
    endcase
  end

  always_comb begin
    final_step = 4'd0;
    sel_byte   = 8'd0;
    case (head_job.kind)
      JOB_START: begin
        final_step = 4'd3 + {2'd0, head_job.nlen_m1} + (head_job.with_id ? 4'd2 : 4'd0);
        if (step == 4'd0) begin
          sel_byte = head_job.first;
        end else if (step <= {2'd0, head_job.nlen_m1} + 4'd1) begin
          sel_byte = {(vk < head_job.nlen_m1), digit};
        end else begin
          case (tj)
            2'd0:    sel_byte = head_job.tlen[15:8];
            2'd1:    sel_byte = head_job.tlen[7:0];
            2'd2:    sel_byte = head_job.pid[15:8];
            default: sel_byte = head_job.pid[7:0];
          endcase
        end
      end
      JOB_DATA: begin
        final_step = head_job.with_id ? 4'd2 : 4'd0;
        case (step)
          4'd0:    sel_byte = head_job.first;
          4'd1:    sel_byte = head_job.pid[15:8];
          default: sel_byte = head_job.pid[7:0];
        endcase
      end
      default: begin
        final_step = 4'd0;
        sel_byte   = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        step      <= is_final ? 4'd0 : step + 4'd1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte  <= sel_byte;
      last      <= is_final && head_job.last;
      status    <= (head_job.kind == JOB_ERR);
      total_len <= (head_job.kind == JOB_DATA) ? 29'd0 : head_job.total;
    end
  end

endmodule

// File: sv/mqtt_publish_packet_framer.sv
// Top level of the MQTT PUBLISH packet framer.
//
//  channel  direction  handshake              payload
//  cfg      in         cfg_valid / cfg_ready  cfg_data (max_packet_size)
//  in       in         in_valid / in_stall    command, topic_len, payload_len, qos,
//                                             retain, packet_id, data_byte
//  out      out        out_valid / out_stall  out_byte, last, status, total_len
//
// Input takes one item per cycle while the job queue has room.
// Output gives one byte per cycle unless stalled: a start item expands to 4..9 bytes
// (1 for an error), a data item to 1 or 3, so the back sequencer sets the sustained rate.
// With the queue empty, an item's first byte passes the queue, then the output register.
// Reset empties the queue and sets max_packet_size to 1024.
// out_stall holds the output register; the queue absorbs items meanwhile.
module mqtt_publish_packet_framer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [28:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [15:0] topic_len,
  input  logic [27:0] payload_len,
  input  logic [1:0]  qos,
  input  logic        retain,
  input  logic [15:0] packet_id,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        last,
  output logic        status,
  output logic [28:0] total_len
);
  import mpf_pkg::*;

  logic push;
  logic q_full;
  logic head_valid;
  logic pop;
  job_t push_job;
  job_t head_job;

  assign cfg_ready = 1'b1;

  mpf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .q_full      (q_full),
    .command     (command),
    .topic_len   (topic_len),
    .payload_len (payload_len),
    .qos         (qos),
    .retain      (retain),
    .packet_id   (packet_id),
    .data_byte   (data_byte),
    .in_stall    (in_stall),
    .push        (push),
    .job         (push_job)
  );

  mpf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  mpf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .out_stall  (out_stall),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_byte   (out_byte),
    .last       (last),
    .status     (status),
    .total_len  (total_len)
  );

endmodule
